FILE: rtl/point_in_polygon_test_core_macros.svh
`ifndef POINT_IN_POLYGON_TEST_CORE_MACROS_SVH
`define POINT_IN_POLYGON_TEST_CORE_MACROS_SVH

// Same-cycle implication on clk, masked while reset is asserted
`define PIPT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, masked while reset is asserted
`define PIPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pipt_pkg.sv
package pipt_pkg;

	// Polygon storage and coordinate format
	localparam int MAX_SIDES   = 10;
	localparam int COORD_WIDTH = 16;
	localparam int SIDE_LOW    = 3;
	localparam int SIDE_HIGH   = (MAX_SIDES < 10) ? MAX_SIDES : 10;
	localparam int SIDE_W      = 4;
	localparam int CNT_W       = 4;
	localparam int IDX_W       = $clog2(MAX_SIDES);

	// Datapath widths: shifted vertex, differences, cross products
	localparam int SH_W = COORD_WIDTH + 1;
	localparam int DF_W = COORD_WIDTH + 2;
	localparam int PR_W = 2 * DF_W;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] CFG_SIDE_COUNT = 2'd0;
	localparam logic [1:0] CFG_CENTER_X   = 2'd1;
	localparam logic [1:0] CFG_CENTER_Y   = 2'd2;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_SKIP,
		KIND_QUERY
	} item_kind_t;

	typedef struct packed {
		item_kind_t                     kind;
		logic [IDX_W-1:0]               slot;
		logic signed [COORD_WIDTH-1:0]  x;
		logic signed [COORD_WIDTH-1:0]  y;
	} item_t;

	typedef struct packed {
		logic             done;
		logic             is_in;
		logic [CNT_W-1:0] count;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} back_state_t;

endpackage

FILE: rtl/pipt_front.sv
module pipt_front import pipt_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          cmd,
	input  logic [3:0]                    vertex_index,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	output logic                          busy,
	output item_t                         q_item,
	output logic                          q_valid,
	input  logic                          q_pop
);

	item_t             fifo_q [QUEUE_DEPTH];
	item_t             in_item;
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;

	function automatic logic [QPTR_W-1:0] ptr_next(logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	// Classify the incoming transaction
	always_comb begin
		in_item.slot = vertex_index[IDX_W-1:0];
		in_item.x    = coord_x;
		in_item.y    = coord_y;
		if (cmd == CMD_QUERY) begin
			in_item.kind = KIND_QUERY;
		end else if ({1'b0, vertex_index} < 5'(MAX_SIDES)) begin
			in_item.kind = KIND_WRITE;
		end else begin
			in_item.kind = KIND_SKIP;
		end
	end

	assign busy    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = fifo_q[rd_ptr_q];
	assign push    = start && !busy;

	// Store accepted items
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (q_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !q_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push && q_pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/pipt_back.sv
module pipt_back import pipt_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  item_t                         q_item,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  logic [IDX_W-1:0]              last_idx,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	output result_t                       res
);

	back_state_t state_q;
	back_state_t state_d;

	logic signed [COORD_WIDTH-1:0] vx_mem [MAX_SIDES];
	logic signed [COORD_WIDTH-1:0] vy_mem [MAX_SIDES];

	logic [IDX_W-1:0]              edge_q;
	logic [IDX_W-1:0]              next_idx;
	logic                          issue;
	logic                          take_query;
	logic                          take_other;
	logic signed [COORD_WIDTH-1:0] qx_q;
	logic signed [COORD_WIDTH-1:0] qy_q;

	// Stage 1: vertex reads
	logic                          v_s1, last_s1;
	logic signed [COORD_WIDTH-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	// Stage 2: shifted vertices
	logic                          v_s2, last_s2;
	logic signed [SH_W-1:0]        ax_s2, ay_s2, bx_s2, by_s2;
	// Stage 3: span and differences
	logic                          v_s3, last_s3, span_s3;
	logic signed [DF_W-1:0]        dqy_s3, dxr_s3, dyr_s3, dxq_s3;
	// Stage 4: cross products
	logic                          v_s4, last_s4, span_s4;
	logic signed [PR_W-1:0]        p1_s4, p2_s4;

	logic signed [SH_W-1:0]        lx, ly, rx, ry;
	logic signed [DF_W-1:0]        qx_e, qy_e, lx_e, ly_e, rx_e, ry_e;
	logic                          hit;
	logic [CNT_W-1:0]              cnt_q;
	logic [CNT_W-1:0]              count_sum;
	logic                          res_done_q;
	logic                          res_is_in_q;
	logic [CNT_W-1:0]              res_count_q;

	function automatic logic signed [SH_W-1:0] shift_add(
		logic signed [COORD_WIDTH-1:0] v,
		logic signed [COORD_WIDTH-1:0] c
	);
		return SH_W'(v) + SH_W'(c);
	endfunction

	// Next state of the edge walker
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid && q_item.kind == KIND_QUERY) state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (edge_q == last_idx) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (v_s4 && last_s4) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Walker outputs
	always_comb begin
		q_pop      = (state_q == ST_IDLE) && q_valid;
		issue      = (state_q == ST_ISSUE);
		take_query = q_pop && (q_item.kind == KIND_QUERY);
		take_other = q_pop && (q_item.kind != KIND_QUERY);
	end

	assign next_idx = (edge_q == last_idx) ? '0 : edge_q + IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			edge_q  <= '0;
		end else begin
			state_q <= state_d;
			if (take_query) begin
				edge_q <= '0;
			end else if (issue) begin
				edge_q <= next_idx;
			end
		end
	end

	// Vertex memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (q_pop && q_item.kind == KIND_WRITE) begin
			vx_mem[q_item.slot] <= q_item.x;
			vy_mem[q_item.slot] <= q_item.y;
		end
		if (issue) begin
			ax_s1 <= vx_mem[edge_q];
			ay_s1 <= vy_mem[edge_q];
			bx_s1 <= vx_mem[next_idx];
			by_s1 <= vy_mem[next_idx];
		end
	end

	// Hold the query point
	always_ff @(posedge clk) begin
		if (take_query) begin
			qx_q <= q_item.x;
			qy_q <= q_item.y;
		end
	end

	// Order the edge ends left to right
	always_comb begin
		if (ax_s2 < bx_s2) begin
			lx = ax_s2; ly = ay_s2; rx = bx_s2; ry = by_s2;
		end else begin
			lx = bx_s2; ly = by_s2; rx = ax_s2; ry = ay_s2;
		end
		qx_e = DF_W'(qx_q);
		qy_e = DF_W'(qy_q);
		lx_e = DF_W'(lx);
		ly_e = DF_W'(ly);
		rx_e = DF_W'(rx);
		ry_e = DF_W'(ry);
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		ax_s2   <= shift_add(ax_s1, center_x);
		ay_s2   <= shift_add(ay_s1, center_y);
		bx_s2   <= shift_add(bx_s1, center_x);
		by_s2   <= shift_add(by_s1, center_y);
		span_s3 <= (qx_e > lx_e) && (qx_e <= rx_e);
		dqy_s3  <= qy_e - ly_e;
		dxr_s3  <= rx_e - lx_e;
		dyr_s3  <= ry_e - ly_e;
		dxq_s3  <= qx_e - lx_e;
		span_s4 <= span_s3;
		p1_s4   <= dqy_s3 * dxr_s3;
		p2_s4   <= dyr_s3 * dxq_s3;
	end

	// Stage valid and last-edge marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; last_s1 <= 1'b0;
			v_s2 <= 1'b0; last_s2 <= 1'b0;
			v_s3 <= 1'b0; last_s3 <= 1'b0;
			v_s4 <= 1'b0; last_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			last_s1 <= issue && (edge_q == last_idx);
			v_s2 <= v_s1; last_s2 <= last_s1;
			v_s3 <= v_s2; last_s3 <= last_s2;
			v_s4 <= v_s3; last_s4 <= last_s3;
		end
	end

	// Count edges whose line lies at or above the point
	assign hit       = v_s4 && span_s4 && (p1_s4 <= p2_s4);
	assign count_sum = cnt_q + CNT_W'(hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			res_done_q <= 1'b0;
		end else begin
			if (take_query) begin
				cnt_q <= '0;
			end else if (v_s4) begin
				cnt_q <= count_sum;
			end
			res_done_q <= take_other || (v_s4 && last_s4);
		end
	end

	// Result payload: zero for writes, final count for queries
	always_ff @(posedge clk) begin
		if (take_other) begin
			res_is_in_q <= 1'b0;
			res_count_q <= '0;
		end else if (v_s4 && last_s4) begin
			res_is_in_q <= count_sum[0];
			res_count_q <= count_sum;
		end
	end

	assign res.done  = res_done_q;
	assign res.is_in = res_is_in_q;
	assign res.count = res_count_q;

endmodule

FILE: rtl/point_in_polygon_test_core.sv
// Ray-casting point-in-polygon tester.
// Input channel: a transaction is taken on a clock edge with start high and busy
// low. cmd=0 writes vertex (coord_x, coord_y) to slot vertex_index; cmd=1 asks
// whether point (coord_x, coord_y) lies inside the polygon of side_count vertices,
// each shifted by (center_x, center_y). A two-entry queue parts the front from
// the edge walker, so busy rises only when both entries are taken.
// Result channel: every transaction gives one result, shown for one cycle with
// done high; inside_res and crossing_count are 0 for a vertex write.
// A write is answered once the idle walker pops it, one a cycle while the walker
// is idle. A query walks one edge per cycle through the vertex memory read ports
// and a four-stage shift, difference, multiply and count pipe, and holds the
// walker until its last edge leaves the pipe; items behind it wait in the queue.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 side_count, 1 center_x,
// 2 center_y) and cfg_data; cfg_ready is always high. Write only while idle.
// Reset: side_count 3, centre 0, queue empty, no result pending. The vertex
// slots hold nothing until written. The receiver cannot stall the results.
`include "point_in_polygon_test_core_macros.svh"

module point_in_polygon_test_core import pipt_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [3:0]                    vertex_index,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	output logic                          done,
	output logic                          inside_res,
	output logic [CNT_W-1:0]              crossing_count,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [COORD_WIDTH-1:0]        cfg_data
);

	logic [SIDE_W-1:0]             side_count_q;
	logic signed [COORD_WIDTH-1:0] center_x_q;
	logic signed [COORD_WIDTH-1:0] center_y_q;
	logic [SIDE_W-1:0]             n_sides;
	logic [IDX_W-1:0]              last_idx;
	item_t                         q_item;
	logic                          q_valid;
	logic                          q_pop;
	result_t                       res;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_count_q <= SIDE_W'(SIDE_LOW);
			center_x_q   <= '0;
			center_y_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SIDE_COUNT: side_count_q <= cfg_data[SIDE_W-1:0];
				CFG_CENTER_X:   center_x_q   <= cfg_data;
				CFG_CENTER_Y:   center_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the side count and derive the last vertex slot
	always_comb begin
		priority if (side_count_q < SIDE_W'(SIDE_LOW)) begin
			n_sides = SIDE_W'(SIDE_LOW);
		end else if (side_count_q > SIDE_W'(SIDE_HIGH)) begin
			n_sides = SIDE_W'(SIDE_HIGH);
		end else begin
			n_sides = side_count_q;
		end
	end

	assign last_idx = IDX_W'(n_sides - SIDE_W'(1));

	pipt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cmd          (cmd),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.busy         (busy),
		.q_item       (q_item),
		.q_valid      (q_valid),
		.q_pop        (q_pop)
	);

	pipt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_item   (q_item),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.last_idx (last_idx),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.res      (res)
	);

	assign done           = res.done;
	assign inside_res     = res.is_in;
	assign crossing_count = res.count;

	`PIPT_ASSERT_NOW(a_parity, done, inside_res == crossing_count[0], "inside flag disagrees with count parity")
	`PIPT_ASSERT_NOW(a_count_range, done, crossing_count <= CNT_W'(SIDE_HIGH), "crossing count exceeds side limit")
	`PIPT_ASSERT_NEXT(a_queue_fill, start && !busy, q_valid, "accepted transaction missing from queue")
	`PIPT_ASSERT_NOW(a_pop_valid, q_pop, q_valid, "queue popped while empty")

endmodule

FILE: tb/sv/point_in_polygon_test_core_test.sv
`timescale 1ns / 100ps

module point_in_polygon_test_core_test;
	import pipt_pkg::*;

	localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_TICKS = 24;
	localparam logic FIXED      = 1'b1;
	localparam logic PREDICTED  = 1'b0;

	typedef struct packed {
		logic             is_in;
		logic [CNT_W-1:0] count;
	} outcome_t;

	typedef struct packed {
		logic                          cmd;
		logic [3:0]                    slot;
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic                          fixed_exp;
		outcome_t                      outcome;
	} stim_row_t;

	localparam outcome_t NO_HIT = '{1'b0, 4'd0};
	localparam logic [1:0] REG_ORDER [3] = '{CFG_SIDE_COUNT, CFG_CENTER_X, CFG_CENTER_Y};

	// Directed rows run with reset settings: three sides, centre at the origin
	localparam int N_DIRECTED = 19;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{CMD_WRITE, 4'd0,  C_MIN,    C_MIN,    FIXED,     NO_HIT},
		'{CMD_WRITE, 4'd1,  C_MAX,    C_MIN,    FIXED,     NO_HIT},
		'{CMD_WRITE, 4'd2,  16'sd0,   C_MAX,    FIXED,     NO_HIT},
		// slots past the table are dropped
		'{CMD_WRITE, 4'd15, 16'sd1,   16'sd1,   FIXED,     NO_HIT},
		'{CMD_WRITE, 4'd10, -16'sd1,  -16'sd1,  FIXED,     NO_HIT},
		// top vertex sits on the ray: counted once
		'{CMD_QUERY, 4'd0,  16'sd0,   16'sd0,   PREDICTED, NO_HIT},
		// left of every span
		'{CMD_QUERY, 4'd0,  C_MIN,    16'sd0,   FIXED,     NO_HIT},
		'{CMD_QUERY, 4'd0,  C_MAX,    C_MAX,    PREDICTED, NO_HIT},
		// exactly on the bottom edge
		'{CMD_QUERY, 4'd0,  16'sd0,   C_MIN,    PREDICTED, NO_HIT},
		'{CMD_QUERY, 4'd0,  16'sd0,   C_MAX,    PREDICTED, NO_HIT},
		'{CMD_QUERY, 4'd0,  16'sd1,   -16'sd1,  PREDICTED, NO_HIT},
		'{CMD_QUERY, 4'd0,  -16'sd1,  C_MAX,    PREDICTED, NO_HIT},
		// make the first edge vertical
		'{CMD_WRITE, 4'd1,  C_MIN,    C_MAX,    FIXED,     NO_HIT},
		'{CMD_QUERY, 4'd0,  -16'sd100, 16'sd0,  PREDICTED, NO_HIT},
		'{CMD_QUERY, 4'd0,  C_MIN,    16'sd5,   FIXED,     NO_HIT},
		'{CMD_QUERY, 4'd0,  -16'sd1,  -16'sd1,  PREDICTED, NO_HIT},
		'{CMD_WRITE, 4'd9,  C_MAX,    C_MAX,    FIXED,     NO_HIT},
		'{CMD_QUERY, 4'd0,  C_MAX,    C_MIN,    PREDICTED, NO_HIT},
		'{CMD_QUERY, 4'd0,  -16'sd16384, 16'sd16384, PREDICTED, NO_HIT}
	};

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic                          cmd;
	logic [3:0]                    vertex_index;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;
	logic                          done;
	logic                          inside_res;
	logic [CNT_W-1:0]              crossing_count;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [1:0]                    cfg_index;
	logic [COORD_WIDTH-1:0]        cfg_data;

	// Shadow polygon and settings
	logic signed [COORD_WIDTH-1:0] poly_x [MAX_SIDES];
	logic signed [COORD_WIDTH-1:0] poly_y [MAX_SIDES];
	logic [SIDE_W-1:0]             sides_cfg;
	logic signed [COORD_WIDTH-1:0] ctr_x;
	logic signed [COORD_WIDTH-1:0] ctr_y;

	outcome_t expected_outcomes [$];
	outcome_t oldest;
	int       failures;
	int       quiet_cycles;

	point_in_polygon_test_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.vertex_index   (vertex_index),
		.coord_x        (coord_x),
		.coord_y        (coord_y),
		.done           (done),
		.inside_res     (inside_res),
		.crossing_count (crossing_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Count edges hit by the upward ray from (qx, qy), exact integer math
	function automatic logic [CNT_W-1:0] count_ray_crossings(
		input logic signed [COORD_WIDTH-1:0] qx,
		input logic signed [COORD_WIDTH-1:0] qy
	);
		int               n;
		int               i;
		int               j;
		longint           ax, ay, bx, by, lx, ly, rx, ry, px, py;
		logic [CNT_W-1:0] hits;
		hits = '0;
		px = longint'(qx);
		py = longint'(qy);
		n = int'(sides_cfg);
		if (n < SIDE_LOW) n = SIDE_LOW;
		if (n > SIDE_HIGH) n = SIDE_HIGH;
		for (i = 0; i < n; i++) begin
			j = (i + 1 == n) ? 0 : i + 1;
			ax = longint'(poly_x[i]) + longint'(ctr_x);
			ay = longint'(poly_y[i]) + longint'(ctr_y);
			bx = longint'(poly_x[j]) + longint'(ctr_x);
			by = longint'(poly_y[j]) + longint'(ctr_y);
			if (ax < bx) begin
				lx = ax; ly = ay; rx = bx; ry = by;
			end else begin
				lx = bx; ly = by; rx = ax; ry = ay;
			end
			// half-open span, line at or above the point
			if (px > lx && px <= rx && (py - ly) * (rx - lx) <= (ry - ly) * (px - lx))
				hits++;
		end
		return hits;
	endfunction

	// Random coordinate within +-span of base, wrapped to the port width
	function automatic logic signed [COORD_WIDTH-1:0] near_coord(
		input int                            span,
		input logic signed [COORD_WIDTH-1:0] base
	);
		longint v;
		v = longint'(base) + longint'($urandom_range(2 * span)) - longint'(span);
		return v[COORD_WIDTH-1:0];
	endfunction

	// Send one transaction after a random gap, then record its expected outcome
	task automatic apply_item(input stim_row_t row, input int idle_pct);
		int       gap;
		outcome_t want;
		gap = 0;
		while (gap < 30 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		cmd          <= row.cmd;
		vertex_index <= row.slot;
		coord_x      <= row.x;
		coord_y      <= row.y;
		do @(posedge clk); while (busy);
		want = NO_HIT;
		if (row.cmd == CMD_QUERY) begin
			want.count = count_ray_crossings(row.x, row.y);
			want.is_in = want.count[0];
		end else if (row.slot < MAX_SIDES) begin
			poly_x[row.slot] = row.x;
			poly_y[row.slot] = row.y;
		end
		if (row.fixed_exp)
			want = row.outcome;
		expected_outcomes.push_back(want);
	endtask

	// Hold off the sender until every outstanding result is back
	task automatic settle_outcomes();
		start <= 1'b0;
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// Write all three registers while the block is idle
	task automatic load_settings(
		input logic [COORD_WIDTH-1:0] side_word,
		input logic [COORD_WIDTH-1:0] cx,
		input logic [COORD_WIDTH-1:0] cy
	);
		logic [COORD_WIDTH-1:0] vals [3];
		int                     k;
		settle_outcomes();
		vals[0] = side_word;
		vals[1] = cx;
		vals[2] = cy;
		for (k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= REG_ORDER[k];
			cfg_data  <= vals[k];
			do @(posedge clk); while (!cfg_ready);
			case (REG_ORDER[k])
				CFG_SIDE_COUNT: sides_cfg = vals[k][SIDE_W-1:0];
				CFG_CENTER_X:   ctr_x = vals[k];
				CFG_CENTER_Y:   ctr_y = vals[k];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Lay down a fresh polygon, then mostly queries around it
	task automatic run_phase(input int items, input int idle_pct, input int span);
		stim_row_t row;
		int        k;
		int        r;
		for (k = 0; k < MAX_SIDES; k++) begin
			row = '0;
			row.cmd  = CMD_WRITE;
			row.slot = k[3:0];
			row.x    = near_coord(span, '0);
			row.y    = near_coord(span, '0);
			apply_item(row, idle_pct);
		end
		for (k = 0; k < items; k++) begin
			r = $urandom_range(99);
			row = '0;
			if (r < 12) begin
				row.cmd  = CMD_WRITE;
				row.slot = 4'($urandom_range(15));
				row.x    = near_coord(span, '0);
				row.y    = near_coord(span, '0);
			end else if (r < 20) begin
				row.cmd = CMD_QUERY;
				row.x   = COORD_WIDTH'($urandom);
				row.y   = COORD_WIDTH'($urandom);
			end else begin
				row.cmd = CMD_QUERY;
				row.x   = near_coord(span, ctr_x);
				row.y   = near_coord(span, ctr_y);
			end
			apply_item(row, idle_pct);
			if ($urandom_range(49) == 0)
				settle_outcomes();
		end
	endtask

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_outcomes.size() == 0) begin
				$display("%0t: unexpected result: inside %0d count %0d",
					$time, inside_res, crossing_count);
				failures++;
			end else begin
				oldest = expected_outcomes.pop_front();
				if (inside_res !== oldest.is_in) begin
					$display("%0t: inside_res mismatch: expected %0d actual %0d",
						$time, oldest.is_in, inside_res);
					failures++;
				end
				if (crossing_count !== oldest.count) begin
					$display("%0t: crossing_count mismatch: expected %0d actual %0d",
						$time, oldest.count, crossing_count);
					failures++;
				end
			end
		end
	end

	// Drop the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("Test completed with failures");
					$finish;
				end
			end
		end
	end

	initial begin
		int i;
		failures     = 0;
		quiet_cycles = 0;
		sides_cfg    = SIDE_W'(SIDE_LOW);
		ctr_x        = '0;
		ctr_y        = '0;
		for (i = 0; i < MAX_SIDES; i++) begin
			poly_x[i] = '0;
			poly_y[i] = '0;
		end
		arst_n       <= 1'b0;
		start        <= 1'b0;
		cmd          <= CMD_WRITE;
		vertex_index <= '0;
		coord_x      <= '0;
		coord_y      <= '0;
		cfg_valid    <= 1'b0;
		cfg_index    <= CFG_SIDE_COUNT;
		cfg_data     <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows on reset settings
		for (i = 0; i < N_DIRECTED; i++)
			apply_item(DIRECTED[i], 0);

		// random phases over a spread of settings and idling
		load_settings(16'd10, '0, '0);
		run_phase(110, 0, 300);
		load_settings(16'd0, C_MIN, C_MAX);
		run_phase(100, 74, 32767);
		load_settings(16'd15, C_MAX, C_MIN);
		run_phase(100, 35, 2000);
		load_settings(COORD_WIDTH'($urandom), near_coord(400, '0), near_coord(400, '0));
		run_phase(100, 0, 60);
		load_settings({12'($urandom), 4'd3}, COORD_WIDTH'($urandom), COORD_WIDTH'($urandom));
		run_phase(80, 74, 32767);

		settle_outcomes();
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
